// ===== hdl/kbrl_pkg.sv =====
// shared types, constants and codes of the keyboard report to rollover list block
package kbrl_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_CFG_W = 6;
  localparam int LEN_CFG_W = 6;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int STATUS_W = 2;
  localparam int ARRAY_KEYS = 6;
  localparam int ARRAY_IDX_W = 3;
  localparam int BIT_IDX_W = 3;

  localparam int BITMAP_BYTES_MAX_DEF = 32;
  localparam int KEY_SLOTS_DEF = 6;
  localparam int REPORT_BYTES_MAX_DEF = 64;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ABORT = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPORT_ID = 3'd0,
    CFG_KEYBOARD_PRESENT = 3'd1,
    CFG_MODIFIER_POS = 3'd2,
    CFG_KEYS_POS = 3'd3,
    CFG_KEYS_AS_BITMAP = 3'd4,
    CFG_BITMAP_BYTES = 3'd5
  } kbrl_cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } kbrl_state_e;

  // operation broadcast to every slot cell
  typedef struct packed {
    logic              commit;
    logic              press;
    logic [BYTE_W-1:0] code;
  } kbrl_slot_op_t;

  // search flags rippling from slot to slot
  typedef struct packed {
    logic hit;
    logic empty;
  } kbrl_chain_t;

  typedef struct packed {
    logic [BYTE_W-1:0]                 modifiers;
    logic [ARRAY_KEYS-1:0][BYTE_W-1:0] slots;
    logic [STATUS_W-1:0]               status;
  } kbrl_result_t;

endpackage

// ===== hdl/kbrl_if.sv =====
// valid/ready channel interfaces for report bytes and rollover results
interface kbrl_in_if;
  logic                      valid;
  logic                      ready;
  logic [kbrl_pkg::BYTE_W-1:0] report_byte;
  logic                      last_byte;

  modport source (output valid, output report_byte, output last_byte, input ready);
  modport sink (input valid, input report_byte, input last_byte, output ready);
endinterface

interface kbrl_out_if;
  logic                          valid;
  logic                          ready;
  logic [kbrl_pkg::BYTE_W-1:0]   modifiers;
  logic [kbrl_pkg::BYTE_W-1:0]   key_slot_0;
  logic [kbrl_pkg::BYTE_W-1:0]   key_slot_1;
  logic [kbrl_pkg::BYTE_W-1:0]   key_slot_2;
  logic [kbrl_pkg::BYTE_W-1:0]   key_slot_3;
  logic [kbrl_pkg::BYTE_W-1:0]   key_slot_4;
  logic [kbrl_pkg::BYTE_W-1:0]   key_slot_5;
  logic [kbrl_pkg::STATUS_W-1:0] status;

  modport source (output valid, output modifiers, output key_slot_0, output key_slot_1,
                  output key_slot_2, output key_slot_3, output key_slot_4,
                  output key_slot_5, output status, input ready);
  modport sink (input valid, input modifiers, input key_slot_0, input key_slot_1,
                input key_slot_2, input key_slot_3, input key_slot_4,
                input key_slot_5, input status, output ready);
endinterface

// ===== hdl/kbrl_slot_cell.sv =====
// one held-key slot: insert at first empty slot, shift down on release
module kbrl_slot_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  kbrl_pkg::kbrl_slot_op_t         op_i,
  input  kbrl_pkg::kbrl_chain_t           chain_i,
  output kbrl_pkg::kbrl_chain_t           chain_o,
  input  logic [kbrl_pkg::BYTE_W-1:0]     right_key_i,
  output logic [kbrl_pkg::BYTE_W-1:0]     key_o
);
  import kbrl_pkg::*;

  logic [BYTE_W-1:0] key_q, key_d;
  logic              match;
  logic              empty;
  logic              take_code;
  logic              take_right;

  assign match = (key_q == op_i.code);
  assign empty = (key_q == '0);

  assign chain_o.hit = chain_i.hit | match;
  assign chain_o.empty = chain_i.empty | empty;

  // press lands in the first empty slot, release shifts every slot from the match on
  assign take_code = op_i.press & empty & ~chain_i.empty;
  assign take_right = ~op_i.press & (chain_i.hit | match);

  always_comb begin
    key_d = key_q;
    if (op_i.commit) begin
      if (take_code) begin
        key_d = op_i.code;
      end else if (take_right) begin
        key_d = right_key_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

endmodule

// ===== hdl/key_bitmap_to_rollover_list.sv =====
// top level: keyboard report byte stream to boot-style rollover list result
//
// Report bytes enter one transaction at a time. A byte outside the key bitmap
// (id, modifier, array keys, padding) is taken in without a bit walk. A bitmap
// byte is taken in, and then its bits are walked from low to high, one bit a
// cycle, each changed bit searching and updating the chain of KEY_SLOTS held-key
// cells; a failed press or release ends the walk early. Once the last byte of a
// report is done, the EMIT state loads its result into the output register when
// the output is free; the next report byte is taken while that result still
// waits at the output. Control state, the held keys and the stored previous
// bitmap are cleared directly by reset, so the block is ready at once.
module key_bitmap_to_rollover_list #(
  parameter int BITMAP_BYTES_MAX = kbrl_pkg::BITMAP_BYTES_MAX_DEF,
  parameter int KEY_SLOTS = kbrl_pkg::KEY_SLOTS_DEF,
  parameter int REPORT_BYTES_MAX = kbrl_pkg::REPORT_BYTES_MAX_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kbrl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [kbrl_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  kbrl_in_if.sink                           in_if,
  kbrl_out_if.source                        out_if
);
  import kbrl_pkg::*;

  localparam int POS_W = $clog2(REPORT_BYTES_MAX + 1);
  localparam int CMP_W = (POS_W > POS_CFG_W) ? POS_W : POS_CFG_W;
  localparam int IDX_W = (BITMAP_BYTES_MAX > 1) ? $clog2(BITMAP_BYTES_MAX) : 1;
  localparam logic [BIT_IDX_W-1:0] BIT_LAST = BIT_IDX_W'(BYTE_W - 1);

  // configuration registers
  logic [BYTE_W-1:0]    report_id_q;
  logic                 keyboard_present_q;
  logic [POS_CFG_W-1:0] modifier_pos_q;
  logic [POS_CFG_W-1:0] keys_pos_q;
  logic                 keys_as_bitmap_q;
  logic [LEN_CFG_W-1:0] bitmap_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_id_q <= '0;
      keyboard_present_q <= 1'b0;
      modifier_pos_q <= '0;
      keys_pos_q <= '0;
      keys_as_bitmap_q <= 1'b1;
      bitmap_bytes_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_REPORT_ID:        report_id_q <= cfg_data_i;
        CFG_KEYBOARD_PRESENT: keyboard_present_q <= cfg_data_i[0];
        CFG_MODIFIER_POS:     modifier_pos_q <= cfg_data_i[POS_CFG_W-1:0];
        CFG_KEYS_POS:         keys_pos_q <= cfg_data_i[POS_CFG_W-1:0];
        CFG_KEYS_AS_BITMAP:   keys_as_bitmap_q <= cfg_data_i[0];
        CFG_BITMAP_BYTES:     bitmap_bytes_q <= cfg_data_i[LEN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // control and per-report state
  kbrl_state_e           state_q, state_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic                  rej_q, abort_q;
  logic [BYTE_W-1:0]     mod_q;
  logic [BYTE_W-1:0]     arr_q [ARRAY_KEYS];
  logic [BYTE_W-1:0]     prev_q [BITMAP_BYTES_MAX];
  logic [BYTE_W-1:0]     byte_q;
  logic                  last_q;
  logic [IDX_W-1:0]      idx_q;
  logic [BIT_IDX_W-1:0]  bit_q;
  logic                  out_valid_q;
  kbrl_result_t          out_q, result;

  logic                  in_ready;
  logic                  scanning;
  logic                  emitting;
  logic                  in_acc;
  logic                  first;
  logic                  rej_new, abort_new;
  logic                  in_range, live, keys_hit, scan_start;
  logic                  mod_take, arr_take;
  logic [CMP_W-1:0]      pos_c, kpos_c, mpos_c, rel;
  logic [LEN_CFG_W-1:0]  len;
  logic                  scan_fail, scan_end, emit_load;

  // slot chain
  kbrl_slot_op_t         slot_op;
  kbrl_chain_t           chain [KEY_SLOTS+1];
  logic [BYTE_W-1:0]     held [KEY_SLOTS];
  logic [BYTE_W-1:0]     prev_byte;
  logic                  bit_now, changed, op_ok;

  assign in_acc = in_if.valid & in_ready;
  assign first = (pos_q == '0);
  assign rej_new = first ? (~keyboard_present_q |
                            ((report_id_q != '0) & (in_if.report_byte != report_id_q)))
                         : rej_q;
  assign abort_new = first ? 1'b0 : abort_q;
  assign pos_c = CMP_W'(pos_q);
  assign kpos_c = CMP_W'(keys_pos_q);
  assign mpos_c = CMP_W'(modifier_pos_q);
  assign rel = pos_c - kpos_c;
  assign in_range = (pos_q < POS_W'(REPORT_BYTES_MAX));
  assign live = in_range & ~rej_new;
  assign keys_hit = (pos_c >= kpos_c);
  assign len = (bitmap_bytes_q > LEN_CFG_W'(BITMAP_BYTES_MAX)) ?
               LEN_CFG_W'(BITMAP_BYTES_MAX) : bitmap_bytes_q;
  assign scan_start = live & keys_hit & keys_as_bitmap_q & ~abort_new &
                      (rel < CMP_W'(len));
  assign mod_take = live & (pos_c == mpos_c);
  assign arr_take = live & keys_hit & ~keys_as_bitmap_q & (rel < CMP_W'(ARRAY_KEYS));
  assign pos_d = in_range ? pos_q + 1'b1 : pos_q;

  // bit walk of the current bitmap byte
  assign prev_byte = prev_q[idx_q];
  assign bit_now = byte_q[bit_q];
  assign changed = bit_now ^ prev_byte[bit_q];
  assign op_ok = bit_now ? chain[KEY_SLOTS].empty : chain[KEY_SLOTS].hit;
  assign slot_op.commit = scanning & changed & op_ok;
  assign slot_op.press = bit_now;
  assign slot_op.code = BYTE_W'({idx_q, bit_q});
  assign scan_fail = scanning & changed & ~op_ok;
  assign scan_end = scan_fail | (bit_q == BIT_LAST);
  assign emit_load = emitting & (~out_valid_q | out_if.ready);

  assign chain[0] = '{hit: 1'b0, empty: 1'b0};

  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_slot
    logic [BYTE_W-1:0] right_key;
    if (i < KEY_SLOTS - 1) begin : g_mid
      assign right_key = held[i+1];
    end else begin : g_end
      assign right_key = '0;
    end
    kbrl_slot_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (slot_op),
      .chain_i     (chain[i]),
      .chain_o     (chain[i+1]),
      .right_key_i (right_key),
      .key_o       (held[i])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (scan_start) begin
            state_d = ST_SCAN;
          end else if (in_if.last_byte) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state decode
  always_comb begin
    in_ready = 1'b0;
    scanning = 1'b0;
    emitting = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready = 1'b1;
      ST_SCAN: scanning = 1'b1;
      ST_EMIT: emitting = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q <= '0;
      rej_q <= 1'b0;
      abort_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        pos_q <= pos_d;
        rej_q <= rej_new;
        abort_q <= abort_new;
      end else if (scan_fail) begin
        abort_q <= 1'b1;
      end else if (emit_load) begin
        pos_q <= '0;
        rej_q <= 1'b0;
        abort_q <= 1'b0;
      end
    end
  end

  // modifier and array capture, cleared at the first byte of a report
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= '0;
      for (int k = 0; k < ARRAY_KEYS; k++) begin
        arr_q[k] <= '0;
      end
    end else if (in_acc) begin
      if (mod_take) begin
        mod_q <= in_if.report_byte;
      end else if (first) begin
        mod_q <= '0;
      end
      for (int k = 0; k < ARRAY_KEYS; k++) begin
        if (arr_take && rel[ARRAY_IDX_W-1:0] == ARRAY_IDX_W'(k)) begin
          arr_q[k] <= in_if.report_byte;
        end else if (first) begin
          arr_q[k] <= '0;
        end
      end
    end
  end

  // byte under scan
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= in_if.report_byte;
      last_q <= in_if.last_byte;
      idx_q <= rel[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else if (in_acc) begin
      bit_q <= '0;
    end else if (scanning) begin
      bit_q <= bit_q + 1'b1;
    end
  end

  // previous bitmap follows each committed press or release
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < BITMAP_BYTES_MAX; k++) begin
        prev_q[k] <= '0;
      end
    end else if (slot_op.commit) begin
      prev_q[idx_q][bit_q] <= bit_now;
    end
  end

  // result assembly
  for (genvar j = 0; j < ARRAY_KEYS; j++) begin : g_out_slot
    logic [BYTE_W-1:0] held_key;
    if (j < KEY_SLOTS) begin : g_held
      assign held_key = held[j];
    end else begin : g_none
      assign held_key = '0;
    end
    assign result.slots[j] = rej_q ? '0 : (keys_as_bitmap_q ? held_key : arr_q[j]);
  end

  assign result.modifiers = rej_q ? '0 : mod_q;
  assign result.status = rej_q ? STATUS_REJECT : (abort_q ? STATUS_ABORT : STATUS_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_q <= result;
    end
  end

  assign in_if.ready = in_ready;
  assign out_if.valid = out_valid_q;
  assign out_if.modifiers = out_q.modifiers;
  assign out_if.key_slot_0 = out_q.slots[0];
  assign out_if.key_slot_1 = out_q.slots[1];
  assign out_if.key_slot_2 = out_q.slots[2];
  assign out_if.key_slot_3 = out_q.slots[3];
  assign out_if.key_slot_4 = out_q.slots[4];
  assign out_if.key_slot_5 = out_q.slots[5];
  assign out_if.status = out_q.status;

  // held list never has a key behind an empty slot
  logic list_gap;
  always_comb begin
    list_gap = 1'b0;
    for (int i = 0; i < KEY_SLOTS - 1; i++) begin
      if (held[i] == '0 && held[i+1] != '0) begin
        list_gap = 1'b1;
      end
    end
  end

  a_list_compact: assert property (@(posedge clk_i) disable iff (!rst_ni) !list_gap)
    else $error("held key list has a gap");

  a_fail_aborts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_fail |=> abort_q)
    else $error("failed press or release did not abort the report");

  a_reject_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.status == STATUS_REJECT) |->
      (out_if.modifiers == '0 && out_if.key_slot_0 == '0))
    else $error("rejected report carries key data");

endmodule
